[rtl/bti_pkg.sv]
// ----------------------------------------------------------------------------
// bti_pkg: shared types and constants for the byte trie
// Request codes, field widths, default sizes and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bti_pkg;

   localparam int MAX_NODES_DEF = 256;
   localparam int SYMBOLS_DEF   = 256;

   localparam int REQ_TYPE_W   = 2;
   localparam int SYMBOL_W     = 8;
   localparam int NODES_USED_W = 9;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_LOOKUP = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic load_req;     // capture request, read child entry
      logic commit;       // apply read result, write child, update walk
      logic sweep;        // write one zero entry of the clearing pass
      logic sweep_start;  // restart clearing pass and walk state
   } cmd_type;

   typedef struct packed {
      logic sweep_last;   // clearing pass stands on its last entry
      logic can_commit;   // result register can take what commit produces
   } status_type;

endpackage

[rtl/bti_if.sv]
// ----------------------------------------------------------------------------
// bti_if: request and response channels of the byte trie
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface bti_req_if;
   logic                                valid;
   logic                                ready;
   logic [bti_pkg::REQ_TYPE_W-1:0]      req_type;
   logic [bti_pkg::SYMBOL_W-1:0]        symbol;

   modport source (output valid, output req_type, output symbol, input ready);
   modport sink   (input valid, input req_type, input symbol, output ready);
endinterface

interface bti_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                found;
   logic                                full_res;
   logic [bti_pkg::NODES_USED_W-1:0]    nodes_used;

   modport source (output valid, output found, output full_res, output nodes_used,
                   input ready);
   modport sink   (input valid, input found, input full_res, input nodes_used,
                   output ready);
endinterface

[rtl/bti_ctrl.sv]
// ----------------------------------------------------------------------------
// bti_ctrl: controller of the byte trie
// Sequences the clearing pass, request acceptance and the commit step.
// ----------------------------------------------------------------------------
module bti_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  bti_pkg::req_kind_type req_kind,
   output logic                  req_ready,
   input  bti_pkg::status_type   status,
   output bti_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_kind)
                  bti_pkg::REQ_INSERT,
                  bti_pkg::REQ_LOOKUP: begin
                     cmd.load_req = 1'b1;
                     state_in     = ST_DECIDE;
                  end
                  bti_pkg::REQ_CLEAR: begin
                     cmd.sweep_start = 1'b1;
                     state_in        = ST_CLEAR;
                  end
                  bti_pkg::REQ_NONE: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DECIDE: begin
            // hold until the result register has room
            if (status.can_commit) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/bti_datapath.sv]
// ----------------------------------------------------------------------------
// bti_datapath: child table, walk registers and result register
// Holds the child table memory, the clearing sweep counter, the walk state,
// node allocation and the registered response.
// ----------------------------------------------------------------------------
module bti_datapath #(
   parameter int MAX_NODES = bti_pkg::MAX_NODES_DEF,
   parameter int SYMBOLS   = bti_pkg::SYMBOLS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bti_pkg::cmd_type                  cmd,
   output bti_pkg::status_type               status,
   input  logic [bti_pkg::REQ_TYPE_W-1:0]    req_type,
   input  logic [bti_pkg::SYMBOL_W-1:0]      symbol,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic                              rsp_full_res,
   output logic [bti_pkg::NODES_USED_W-1:0]  rsp_nodes_used
);

   localparam int DEPTH   = MAX_NODES * SYMBOLS;
   localparam int AW      = $clog2(DEPTH);
   localparam int NW      = $clog2(MAX_NODES);
   localparam int CW      = $clog2(MAX_NODES + 1);
   localparam int SW      = $clog2(SYMBOLS);
   localparam int SYM_NUM = 2 ** bti_pkg::SYMBOL_W;

   // child table: entry (node, symbol) holds the child node, zero if absent
   logic [NW-1:0] child_mem [DEPTH];
   logic [NW-1:0] rd_data_ff;

   logic [SW-1:0] sym_mod_tbl [SYM_NUM];
   logic [SW-1:0] sym_idx;
   logic [AW-1:0] rd_addr;

   logic [AW-1:0] sweep_cnt_ff;
   logic [AW-1:0] sweep_cnt_in;

   logic [AW-1:0] addr_ff;
   logic          insert_ff;
   logic          zero_sym_ff;

   logic [NW-1:0] walk_node_ff, walk_node_in;
   logic [CW-1:0] node_count_ff, node_count_in;
   logic          alloc_any_ff, alloc_any_in;
   logic          failed_ff, failed_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          found_ff, found_in;
   logic          full_res_ff, full_res_in;
   logic [bti_pkg::NODES_USED_W-1:0] nodes_used_ff, nodes_used_in;

   logic          miss;
   logic          store_full;
   logic          fail_now;
   logic          alloc;
   logic [CW-1:0] count_next;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [NW-1:0] mem_wdata;

   // symbol index into a row, taken modulo the alphabet size
   for (genvar g = 0; g < SYM_NUM; g++) begin : g_sym_mod
      assign sym_mod_tbl[g] = SW'(g % SYMBOLS);
   end

   assign sym_idx = sym_mod_tbl[symbol];
   assign rd_addr = AW'(walk_node_ff) * AW'(SYMBOLS) + AW'(sym_idx);

   assign miss       = (rd_data_ff == '0);
   assign store_full = (node_count_ff >= CW'(MAX_NODES));
   assign fail_now   = failed_ff || (miss && (!insert_ff || store_full));
   assign alloc      = !failed_ff && miss && insert_ff && !store_full;
   assign count_next = alloc ? node_count_ff + CW'(1) : node_count_ff;

   assign status.sweep_last = (sweep_cnt_ff == AW'(DEPTH - 1));
   assign status.can_commit = !zero_sym_ff || !rsp_valid_ff || rsp_ready;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = NW'(node_count_ff);
      if (cmd.sweep) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_cnt_ff;
         mem_wdata = '0;
      end else if (cmd.commit && alloc) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         child_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rd_data_ff <= child_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         addr_ff     <= rd_addr;
         insert_ff   <= (bti_pkg::req_kind_type'(req_type) == bti_pkg::REQ_INSERT);
         zero_sym_ff <= (symbol == '0);
      end
   end

   always_comb begin
      sweep_cnt_in  = sweep_cnt_ff;
      walk_node_in  = walk_node_ff;
      node_count_in = node_count_ff;
      alloc_any_in  = alloc_any_ff;
      failed_in     = failed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      found_in      = found_ff;
      full_res_in   = full_res_ff;
      nodes_used_in = nodes_used_ff;
      priority if (cmd.sweep_start) begin
         sweep_cnt_in  = '0;
         walk_node_in  = '0;
         node_count_in = CW'(1);
         alloc_any_in  = 1'b0;
         failed_in     = 1'b0;
      end else if (cmd.sweep) begin
         sweep_cnt_in = sweep_cnt_ff + AW'(1);
      end else if (cmd.commit) begin
         node_count_in = count_next;
         if (zero_sym_ff) begin
            // end of string: report and return to the root
            rsp_valid_in  = 1'b1;
            found_in      = insert_ff ? (!fail_now && !(alloc_any_ff || alloc)) : !fail_now;
            full_res_in   = insert_ff && fail_now;
            nodes_used_in = bti_pkg::NODES_USED_W'(count_next);
            walk_node_in  = '0;
            alloc_any_in  = 1'b0;
            failed_in     = 1'b0;
         end else begin
            if (!fail_now) begin
               walk_node_in = alloc ? NW'(node_count_ff) : rd_data_ff;
            end
            alloc_any_in = alloc_any_ff || alloc;
            failed_in    = fail_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff  <= '0;
         walk_node_ff  <= '0;
         node_count_ff <= CW'(1);
         alloc_any_ff  <= 1'b0;
         failed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sweep_cnt_ff  <= sweep_cnt_in;
         walk_node_ff  <= walk_node_in;
         node_count_ff <= node_count_in;
         alloc_any_ff  <= alloc_any_in;
         failed_ff     <= failed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff      <= found_in;
      full_res_ff   <= full_res_in;
      nodes_used_ff <= nodes_used_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_full_res   = full_res_ff;
   assign rsp_nodes_used = nodes_used_ff;

endmodule

[rtl/byte_trie_insert_lookup.sv]
// ----------------------------------------------------------------------------
// byte_trie_insert_lookup: 256-way byte trie with insert and lookup
// Strings arrive one byte per request; a zero byte ends the string and
// returns found, full and the count of nodes in use.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    req_type[1:0], symbol[7:0]
//   rsp_ch   out  valid/ready    found, full_res, nodes_used[8:0]
//
// An insert or lookup byte first reads the child table memory, then
// decides, allocates and writes back; the next byte's address depends on
// that read. Clear and unused requests need no decide step.
// After reset and after each clear a sweep zeroes all MAX_NODES * SYMBOLS
// entries of the child table, one entry a cycle, with req_ch.ready low.
// A finished response waits in its register; the next request is taken
// meanwhile and stalls only in its decide cycle if it must respond too.
// ----------------------------------------------------------------------------
module byte_trie_insert_lookup #(
   parameter int MAX_NODES = bti_pkg::MAX_NODES_DEF,
   parameter int SYMBOLS   = bti_pkg::SYMBOLS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   bti_req_if.sink      req_ch,
   bti_rsp_if.source    rsp_ch
);

   bti_pkg::cmd_type    cmd;
   bti_pkg::status_type status;

   bti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (bti_pkg::req_kind_type'(req_ch.req_type)),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bti_datapath #(
      .MAX_NODES (MAX_NODES),
      .SYMBOLS   (SYMBOLS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_ch.req_type),
      .symbol         (req_ch.symbol),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_found      (rsp_ch.found),
      .rsp_full_res   (rsp_ch.full_res),
      .rsp_nodes_used (rsp_ch.nodes_used)
   );

endmodule
